[rtl/wab_pkg.sv]
// Shared constants, types and helpers for the wrapping alpha-over blitter.
package wab_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int DIMW       = 7;
    localparam int CNTW       = 13;

    // Item modes
    localparam logic [2:0] MODE_WR_SRC = 3'd0;
    localparam logic [2:0] MODE_WR_DST = 3'd1;
    localparam logic [2:0] MODE_RD_DST = 3'd2;
    localparam logic [2:0] MODE_BLEND  = 3'd3;
    localparam logic [2:0] MODE_COPY   = 3'd4;

    // Register indexes
    localparam logic [1:0] REG_DEST_WIDTH  = 2'd0;
    localparam logic [1:0] REG_DEST_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SRC_WIDTH   = 2'd2;
    localparam logic [1:0] REG_SRC_HEIGHT  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the accepted beat
        logic clr_step;   // clear both images, one address per cycle
        logic prep;       // clip the blit rectangle
        logic wrap_u;     // one reduction step of the source column
        logic wrap_v;     // one reduction step of the source row
        logic access;     // perform a single texel access
        logic rd_issue;   // issue blit reads for the current texel
        logic wr_issue;   // write the current blit texel and advance
        logic finish;     // build the result beat
    } wab_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_access;
        logic is_blit;
        logic empty;
        logic u_done;
        logic v_done;
        logic last_px;
    } wab_stat_t;

    // Saturate a register into 1..maxv.
    function automatic logic [DIMW-1:0] sat_dim(input logic [DIMW-1:0] v,
                                                input logic [DIMW-1:0] maxv);
        if (v == '0)
            return DIMW'(1);
        else if (v > maxv)
            return maxv;
        else
            return v;
    endfunction

endpackage

[rtl/wrapping_alpha_over_blitter_core.sv]
// Top level of the wrapping alpha-over blitter.
// A texel access passes through decode, the access and a wait before the result is built;
// unused modes go from decode straight to the result. A blit wraps the source start, then
// reads, waits for registered RAM data and writes back each texel; an empty blit skips both.
// One beat at a time: the next is accepted once the result beat has been taken.
// After reset a clearing pass zeroes both images; no beat is
// accepted meanwhile, configuration writes are taken as ever.
module wrapping_alpha_over_blitter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [6:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic signed [15:0] s_dest_x,
    input  logic signed [15:0] s_dest_y,
    input  logic signed [15:0] s_rect_w,
    input  logic signed [15:0] s_rect_h,
    input  logic signed [15:0] s_src_u,
    input  logic signed [15:0] s_src_v,
    input  logic [31:0] s_texel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_texel,
    output logic        m_status,
    output logic [12:0] m_pixels_drawn
);
    import wab_pkg::*;

    wab_cmd_t  cmd;
    wab_stat_t stat;

    wab_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd));

    wab_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
        .cfg_data(cfg_data), .s_mode(s_mode), .s_dest_x(s_dest_x),
        .s_dest_y(s_dest_y), .s_rect_w(s_rect_w), .s_rect_h(s_rect_h),
        .s_src_u(s_src_u), .s_src_v(s_src_v), .s_texel(s_texel), .cmd(cmd),
        .stat(stat), .m_read_texel(m_read_texel), .m_status(m_status),
        .m_pixels_drawn(m_pixels_drawn));
endmodule

[rtl/wab_ram.sv]
// Generic single-port RAM with registered read.
module wab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: the registered read returns the old data on a write.
    always_ff @(posedge aclk) begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

[rtl/wab_ctrl.sv]
// Controller state machine of the blitter.
module wab_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  wab_pkg::wab_stat_t  stat,
    output wab_pkg::wab_cmd_t   cmd
);
    import wab_pkg::*;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DEC   = 4'd2;
    localparam logic [3:0] ST_ACC   = 4'd3;
    localparam logic [3:0] ST_ACCW  = 4'd4;
    localparam logic [3:0] ST_WRAP  = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_RDW   = 4'd7;
    localparam logic [3:0] ST_WR    = 4'd8;
    localparam logic [3:0] ST_FIN   = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       out_vld_reg, out_vld_next;

    assign s_ready = (state_reg == ST_IDLE) && !out_vld_reg;
    assign m_valid = out_vld_reg;

    // Next-state and command decode.
    always_comb begin
        state_next   = state_reg;
        out_vld_next = out_vld_reg;
        cmd          = '0;
        if (out_vld_reg && m_ready)
            out_vld_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.prep = 1'b1;
                if (stat.is_access)
                    state_next = ST_ACC;
                else if (stat.is_blit)
                    state_next = ST_WRAP;
                else
                    state_next = ST_FIN;
            end
            ST_ACC: begin
                cmd.access = 1'b1;
                state_next = ST_ACCW;
            end
            ST_ACCW: state_next = ST_FIN;
            ST_WRAP: begin
                if (stat.empty)
                    state_next = ST_FIN;
                else if (stat.u_done && stat.v_done)
                    state_next = ST_RD;
                else begin
                    cmd.wrap_u = !stat.u_done;
                    cmd.wrap_v = !stat.v_done;
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RDW;
            end
            // Keep the blit addresses on the RAMs while the read data settles.
            ST_RDW: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR: begin
                cmd.wr_issue = 1'b1;
                state_next   = stat.last_px ? ST_FIN : ST_RD;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                out_vld_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end
endmodule

[rtl/wab_dp.sv]
// Datapath of the blitter: registers, clipping, addressing, blend, images.
module wab_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_idx,
    input  logic [6:0]          cfg_data,
    input  logic [2:0]          s_mode,
    input  logic signed [15:0]  s_dest_x,
    input  logic signed [15:0]  s_dest_y,
    input  logic signed [15:0]  s_rect_w,
    input  logic signed [15:0]  s_rect_h,
    input  logic signed [15:0]  s_src_u,
    input  logic signed [15:0]  s_src_v,
    input  logic [31:0]         s_texel,
    input  wab_pkg::wab_cmd_t   cmd,
    output wab_pkg::wab_stat_t  stat,
    output logic [31:0]         m_read_texel,
    output logic                m_status,
    output logic [12:0]         m_pixels_drawn
);
    import wab_pkg::*;

    localparam logic [DIMW-1:0] MAXW = DIMW'(MAX_WIDTH);
    localparam logic [DIMW-1:0] MAXH = DIMW'(MAX_HEIGHT);

    logic [DIMW-1:0] dw_cfg_reg, dh_cfg_reg, sw_cfg_reg, sh_cfg_reg;
    logic [DIMW-1:0] dwid, dhei, swid, shei;
    logic [2:0]      mode_reg;
    logic signed [17:0] dx_reg, dy_reg, rw_reg, rh_reg, su_reg, sv_reg;
    logic [31:0]     texel_reg;
    logic [AW:0]     clr_reg;
    logic            ok_reg;
    logic [XW-1:0]   cx_reg, x0_reg, tu_reg, tu0_reg;
    logic [YW-1:0]   cy_reg, tv_reg;
    logic [XW:0]     cw_reg;
    logic [YW:0]     ch_reg;
    logic [XW:0]     col_reg;
    logic [YW:0]     row_reg;
    logic [CNTW-1:0] drawn_reg;
    logic [3:0]      wrap_k_reg;
    logic            wrap_pend_reg;
    logic            src_we, dst_we;
    logic [AW-1:0]   src_addr, dst_addr;
    logic [31:0]     src_wd, dst_wd, src_rd, dst_rd, blend_px;

    assign dwid = sat_dim(dw_cfg_reg, MAXW);
    assign dhei = sat_dim(dh_cfg_reg, MAXH);
    assign swid = sat_dim(sw_cfg_reg, MAXW);
    assign shei = sat_dim(sh_cfg_reg, MAXH);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dw_cfg_reg <= MAXW;
            dh_cfg_reg <= MAXH;
            sw_cfg_reg <= MAXW;
            sh_cfg_reg <= MAXH;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_DEST_WIDTH:  dw_cfg_reg <= cfg_data;
                REG_DEST_HEIGHT: dh_cfg_reg <= cfg_data;
                REG_SRC_WIDTH:   sw_cfg_reg <= cfg_data;
                REG_SRC_HEIGHT:  sh_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clip arithmetic on the latched beat (18-bit signed avoids overflow).
    logic signed [17:0] ndx, ndy, nw, nh, nsu, nsv, fw, fh;
    always_comb begin
        nw  = rw_reg;  nsu = su_reg;  ndx = dx_reg;
        nh  = rh_reg;  nsv = sv_reg;  ndy = dy_reg;
        if (dx_reg < 0) begin
            nw  = rw_reg + dx_reg;
            nsu = su_reg - dx_reg;
            ndx = '0;
        end
        if (dy_reg < 0) begin
            nh  = rh_reg + dy_reg;
            nsv = sv_reg - dy_reg;
            ndy = '0;
        end
        fw = nw;
        fh = nh;
        if (ndx + nw > $signed({11'd0, dwid}))
            fw = $signed({11'd0, dwid}) - ndx;
        if (ndy + nh > $signed({11'd0, dhei}))
            fh = $signed({11'd0, dhei}) - ndy;
    end

    // Access range checks.
    logic in_src, in_dst;
    assign in_src = !su_reg[17] && !sv_reg[17] &&
                    su_reg < $signed({11'd0, swid}) && sv_reg < $signed({11'd0, shei});
    assign in_dst = !dx_reg[17] && !dy_reg[17] &&
                    dx_reg < $signed({11'd0, dwid}) && dy_reg < $signed({11'd0, dhei});

    logic signed [17:0] sw_s, sh_s;
    assign sw_s = $signed({11'd0, swid});
    assign sh_s = $signed({11'd0, shei});

    // One stage of a binary reduction by the period scaled by 2^k. Stages run from
    // k = 15 down to 0, one per cycle; the last stage also lifts a negative remainder.
    function automatic logic signed [17:0] wrap_step(input logic signed [17:0] a,
                                                     input logic signed [17:0] m,
                                                     input logic [3:0]         k);
        logic signed [23:0] r;
        logic signed [23:0] ms;
        r  = {{6{a[17]}}, a};
        ms = {{6{m[17]}}, m} <<< k;
        if (r < 0 && (r + ms) <= 0)
            r = r + ms;
        else if (r >= ms)
            r = r - ms;
        if (k == 4'd0 && r < 0)
            r = r + {{6{m[17]}}, m};
        return r[17:0];
    endfunction

    logic signed [17:0] su_w, sv_w;
    assign su_w = wrap_step(su_reg, sw_s, wrap_k_reg);
    assign sv_w = wrap_step(sv_reg, sh_s, wrap_k_reg);

    assign stat.u_done    = !su_reg[17] && su_reg < sw_s;
    assign stat.v_done    = !sv_reg[17] && sv_reg < sh_s;
    assign stat.clr_last  = clr_reg[AW];
    assign stat.is_access = (mode_reg == MODE_WR_SRC) || (mode_reg == MODE_WR_DST) ||
                            (mode_reg == MODE_RD_DST);
    assign stat.is_blit   = (mode_reg == MODE_BLEND) || (mode_reg == MODE_COPY);
    assign stat.empty     = !ok_reg;
    assign stat.last_px   = (col_reg + 1'b1 == cw_reg) && (row_reg + 1'b1 == ch_reg);

    // The source start is taken while a blit is pending and both coordinates are in range.
    always_ff @(posedge aclk) begin
        if (!aresetn)
            wrap_pend_reg <= 1'b0;
        else if (cmd.prep && stat.is_blit)
            wrap_pend_reg <= 1'b1;
        else if (cmd.rd_issue || cmd.finish)
            wrap_pend_reg <= 1'b0;
    end

    // Beat latch, clip results, walk counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
        if (cmd.load) begin
            mode_reg  <= s_mode;
            dx_reg    <= 18'(s_dest_x);
            dy_reg    <= 18'(s_dest_y);
            rw_reg    <= 18'(s_rect_w);
            rh_reg    <= 18'(s_rect_h);
            su_reg    <= 18'(s_src_u);
            sv_reg    <= 18'(s_src_v);
            texel_reg <= s_texel;
            drawn_reg <= '0;
        end
        if (cmd.prep && stat.is_blit) begin
            ok_reg     <= (fw > 0) && (fh > 0);
            su_reg     <= nsu;
            sv_reg     <= nsv;
            cx_reg     <= XW'(ndx);
            cy_reg     <= YW'(ndy);
            x0_reg     <= XW'(ndx);
            cw_reg     <= (XW+1)'(fw);
            ch_reg     <= (YW+1)'(fh);
            col_reg    <= '0;
            row_reg    <= '0;
            wrap_k_reg <= 4'd15;
        end
        if (cmd.wrap_u) su_reg <= su_w;
        if (cmd.wrap_v) sv_reg <= sv_w;
        if ((cmd.wrap_u || cmd.wrap_v) && wrap_k_reg != 4'd0)
            wrap_k_reg <= wrap_k_reg - 1'b1;
        if (wrap_pend_reg && stat.u_done && stat.v_done) begin
            tu_reg  <= XW'(su_reg);
            tu0_reg <= XW'(su_reg);
            tv_reg  <= YW'(sv_reg);
        end
        if (cmd.wr_issue) begin
            drawn_reg <= drawn_reg + 1'b1;
            if (col_reg + 1'b1 == cw_reg) begin
                col_reg <= '0;
                cx_reg  <= x0_reg;
                tu_reg  <= tu0_reg;
                row_reg <= row_reg + 1'b1;
                cy_reg  <= cy_reg + 1'b1;
                tv_reg  <= ({1'b0, tv_reg} + 1'b1 >= shei) ? '0 : tv_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
                cx_reg  <= cx_reg + 1'b1;
                tu_reg  <= ({1'b0, tu_reg} + 1'b1 >= swid) ? '0 : tu_reg + 1'b1;
            end
        end
        if (cmd.finish) begin
            m_read_texel   <= (mode_reg == MODE_RD_DST && in_dst) ? dst_rd : '0;
            m_status       <= (mode_reg == MODE_WR_SRC) ? !in_src :
                              ((mode_reg == MODE_WR_DST || mode_reg == MODE_RD_DST) ?
                               !in_dst : 1'b0);
            m_pixels_drawn <= stat.is_blit ? drawn_reg : '0;
        end
    end

    // Per-channel premultiplied over: (d*inv+127)/255 via reciprocal, saturated add.
    always_comb begin
        logic [7:0]  inv, d, s;
        logic [15:0] p;
        logic [8:0]  q, t;
        inv = 8'd255 - src_rd[31:24];
        blend_px = '0;
        for (int c = 0; c < 4; c++) begin
            d = dst_rd[c*8 +: 8];
            s = src_rd[c*8 +: 8];
            p = 16'(d * inv) + 16'd127;
            q = 9'((p + (p >> 8) + 16'd1) >> 8);
            t = q + {1'b0, s};
            blend_px[c*8 +: 8] = (t > 9'd255) ? 8'd255 : t[7:0];
        end
    end

    // Memory port steering.
    always_comb begin
        src_we   = 1'b0;
        dst_we   = 1'b0;
        src_addr = {sv_reg[YW-1:0], su_reg[XW-1:0]};
        dst_addr = {dy_reg[YW-1:0], dx_reg[XW-1:0]};
        src_wd   = texel_reg;
        dst_wd   = texel_reg;
        if (cmd.clr_step) begin
            src_we   = 1'b1;
            dst_we   = 1'b1;
            src_addr = clr_reg[AW-1:0];
            dst_addr = clr_reg[AW-1:0];
            src_wd   = '0;
            dst_wd   = '0;
        end else if (cmd.access) begin
            src_we = (mode_reg == MODE_WR_SRC) && in_src;
            dst_we = (mode_reg == MODE_WR_DST) && in_dst;
        end else if (cmd.rd_issue || cmd.wr_issue) begin
            src_addr = {tv_reg, tu_reg};
            dst_addr = {cy_reg, cx_reg};
            dst_we   = cmd.wr_issue;
            dst_wd   = (mode_reg == MODE_BLEND) ? blend_px : src_rd;
        end
    end

    wab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_src_ram (
        .aclk(aclk), .we(src_we), .addr(src_addr), .wdata(src_wd), .rdata(src_rd));
    wab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_dst_ram (
        .aclk(aclk), .we(dst_we), .addr(dst_addr), .wdata(dst_wd), .rdata(dst_rd));
endmodule

[rtl/wab_checker.sv]
// Port-level checker for the blitter, bound to the top level.
module wab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_texel,
    input logic        m_status,
    input logic [12:0] m_pixels_drawn
);
    // A result beat stays valid and its read texel holds while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_texel))
        else $error("result beat changed while stalled");

    // No new beat is taken while a result waits.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");

    // An accepted beat does not produce a result in the next cycle.
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid)
        else $error("result too early");

    // Out-of-range status never comes with read data or a count.
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_read_texel == 32'd0 && m_pixels_drawn == 13'd0)
        else $error("status with data");
endmodule

bind wrapping_alpha_over_blitter_core wab_checker u_wab_checker (.*);

[test/blitter_checker.sv]
// Checker for the blitter: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps

module blitter_checker
    import wab_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_idx,
    input  logic [6:0]         cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [15:0] s_dest_x,
    input  logic signed [15:0] s_dest_y,
    input  logic signed [15:0] s_rect_w,
    input  logic signed [15:0] s_rect_h,
    input  logic signed [15:0] s_src_u,
    input  logic signed [15:0] s_src_v,
    input  logic [31:0]        s_texel,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [31:0]        m_read_texel,
    input  logic               m_status,
    input  logic [12:0]        m_pixels_drawn,
    output int                 errors,
    output int                 pending,
    output int                 beats_in,
    output int                 blits_run,
    output int                 texels_drawn
);

    typedef struct packed {
        logic [31:0] texel;
        logic        status;
        logic [12:0] drawn;
    } outcome_t;

    logic [31:0] src_img [DEPTH];
    logic [31:0] dst_img [DEPTH];
    logic [6:0]  dest_w_reg, dest_h_reg, src_w_reg, src_h_reg;
    outcome_t    outcomes_due [$];

    initial begin
        errors       = 0;
        beats_in     = 0;
        blits_run    = 0;
        texels_drawn = 0;
    end

    assign pending = outcomes_due.size();

    // A register is used saturated into 1..64.
    function automatic int eff_dim(input logic [6:0] v);
        if (v == 7'd0)
            return 1;
        else if (v > 7'd64)
            return 64;
        else
            return int'(v);
    endfunction

    function automatic int wrap_coord(input int a, input int m);
        int r;
        r = a % m;
        if (r < 0)
            r += m;
        return r;
    endfunction

    // Premultiplied source-over, per channel with saturation.
    function automatic logic [31:0] blend_over(input logic [31:0] d, input logic [31:0] s);
        int          inv;
        int          p;
        int          q;
        int          t;
        logic [31:0] res;
        inv = 255 - int'(s[31:24]);
        res = '0;
        for (int c = 0; c < 4; c++) begin
            p = int'(d[c*8 +: 8]) * inv + 127;
            q = (p >= 255 * 255) ? 255 : p / 255;
            t = q + int'(s[c*8 +: 8]);
            if (t > 255)
                t = 255;
            res[c*8 +: 8] = t[7:0];
        end
        return res;
    endfunction

    // Clip the rectangle, walk it with wrapped source addressing and update the image.
    task automatic draw_rect(input logic blend, input int du, input int dv, input int dw,
                             input int dh, input int su, input int sv, output int count);
        int dwid;
        int dhei;
        int swid;
        int shei;
        int tu;
        int di;
        int si;
        dwid = eff_dim(dest_w_reg);
        dhei = eff_dim(dest_h_reg);
        swid = eff_dim(src_w_reg);
        shei = eff_dim(src_h_reg);
        count = 0;
        if (du < 0) begin
            dw += du;
            su -= du;
            du = 0;
        end
        if (dv < 0) begin
            dh += dv;
            sv -= dv;
            dv = 0;
        end
        if (du + dw > dwid)
            dw = dwid - du;
        if (dv + dh > dhei)
            dh = dhei - dv;
        if (dw <= 0 || dh <= 0)
            return;
        su = wrap_coord(su, swid);
        sv = wrap_coord(sv, shei);
        for (int i = 0; i < dh; i++) begin
            tu = su;
            for (int j = 0; j < dw; j++) begin
                di = (dv + i) * MAX_WIDTH + du + j;
                si = sv * MAX_WIDTH + tu;
                dst_img[di] = blend ? blend_over(dst_img[di], src_img[si]) : src_img[si];
                tu++;
                if (tu >= swid)
                    tu = 0;
            end
            sv++;
            if (sv >= shei)
                sv = 0;
        end
        count = dw * dh;
    endtask

    // Work out the result of one accepted beat and apply its side effects.
    task automatic apply_beat(output outcome_t o);
        int dx;
        int dy;
        int su;
        int sv;
        int count;
        dx = s_dest_x;
        dy = s_dest_y;
        su = s_src_u;
        sv = s_src_v;
        o  = '0;
        case (s_mode)
            MODE_WR_SRC: begin
                if (su >= 0 && sv >= 0 && su < eff_dim(src_w_reg) && sv < eff_dim(src_h_reg))
                    src_img[sv * MAX_WIDTH + su] = s_texel;
                else
                    o.status = 1'b1;
            end
            MODE_WR_DST, MODE_RD_DST: begin
                if (dx >= 0 && dy >= 0 && dx < eff_dim(dest_w_reg)
                        && dy < eff_dim(dest_h_reg)) begin
                    if (s_mode == MODE_WR_DST)
                        dst_img[dy * MAX_WIDTH + dx] = s_texel;
                    else
                        o.texel = dst_img[dy * MAX_WIDTH + dx];
                end else begin
                    o.status = 1'b1;
                end
            end
            MODE_BLEND, MODE_COPY: begin
                draw_rect(s_mode == MODE_BLEND, dx, dy, int'(s_rect_w), int'(s_rect_h),
                          su, sv, count);
                o.drawn = count[12:0];
                blits_run++;
                texels_drawn += count;
            end
            default: ;
        endcase
    endtask

    // Track registers, predict accepted beats and compare results in order.
    always @(posedge aclk) begin
        outcome_t o;
        outcome_t want;
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                src_img[k] = '0;
                dst_img[k] = '0;
            end
            dest_w_reg = 7'd64;
            dest_h_reg = 7'd64;
            src_w_reg  = 7'd64;
            src_h_reg  = 7'd64;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_DEST_WIDTH:  dest_w_reg = cfg_data;
                    REG_DEST_HEIGHT: dest_h_reg = cfg_data;
                    REG_SRC_WIDTH:   src_w_reg  = cfg_data;
                    REG_SRC_HEIGHT:  src_h_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                apply_beat(o);
                outcomes_due.push_back(o);
                beats_in++;
            end
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    errors++;
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_read_texel !== want.texel) begin
                        $error("read_texel: expected %h, actual %h", want.texel, m_read_texel);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        errors++;
                    end
                    if (m_pixels_drawn !== want.drawn) begin
                        $error("pixels_drawn: expected %0d, actual %0d",
                               want.drawn, m_pixels_drawn);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

[test/testbench.sv]
// Top of the blitter testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
    import wab_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_idx = '0;
    logic [6:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_mode = '0;
    logic signed [15:0] s_dest_x = '0;
    logic signed [15:0] s_dest_y = '0;
    logic signed [15:0] s_rect_w = '0;
    logic signed [15:0] s_rect_h = '0;
    logic signed [15:0] s_src_u = '0;
    logic signed [15:0] s_src_v = '0;
    logic [31:0]        s_texel = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [31:0]        m_read_texel;
    logic               m_status;
    logic [12:0]        m_pixels_drawn;

    int errors;
    int pending;
    int beats_in;
    int blits_run;
    int texels_drawn;
    int tx_idle = 0;
    int rx_idle = 0;
    int cur_dw = 64;
    int cur_dh = 64;
    int cur_sw = 64;
    int cur_sh = 64;

    wrapping_alpha_over_blitter_core dut (.*);

    blitter_checker chk (.*);

    always #4 aclk = ~aclk;

    // Receiver stalls at random.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= rx_idle);

    // Watchdog.
    initial begin
        #40ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int eff(input int v);
        return (v == 0) ? 1 : ((v > 64) ? 64 : v);
    endfunction

    // Offer one beat; valid stays high from one beat to the next unless the sender idles.
    task automatic put_item(input logic [2:0] mode, input int dx, input int dy, input int w,
                            input int h, input int u, input int v, input logic [31:0] tex);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= mode;
        s_dest_x <= dx[15:0];
        s_dest_y <= dy[15:0];
        s_rect_w <= w[15:0];
        s_rect_h <= h[15:0];
        s_src_u  <= u[15:0];
        s_src_v  <= v[15:0];
        s_texel  <= tex;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off until every expected result has come back, then let the block settle.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_dims(input int dw, input int dh, input int sw, input int sh);
        int vals [4];
        vals = '{dw, dh, sw, sh};
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= i[1:0];
            cfg_data <= vals[i][6:0];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        cur_dw = eff(dw);
        cur_dh = eff(dh);
        cur_sw = eff(sw);
        cur_sh = eff(sh);
    endtask

    // Mostly in range, sometimes just outside, now and then anything at all.
    function automatic int pick_coord(input int lim);
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return $signed($urandom_range(16'hFFFF, 0) & 32'hFFFF) - ((r == 0 &&
                   $urandom_range(1)) ? 0 : 0);
        else if (r == 1)
            return -$urandom_range(1, 3);
        else if (r == 2)
            return lim + $urandom_range(0, 2);
        return $urandom_range(lim - 1);
    endfunction

    function automatic int pick_extent(input int lim);
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return $urandom_range(16'hFFFF);
        else if (r < 3)
            return -$urandom_range(0, 3);
        return $urandom_range(1, (lim < 12 ? lim : 12) + 2);
    endfunction

    task automatic random_item;
        int          r;
        logic [2:0]  mode;
        logic [31:0] tex;
        r   = $urandom_range(99);
        tex = $urandom;
        if ($urandom_range(3) == 0)
            tex[31:24] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        if (r < 30)
            mode = MODE_WR_SRC;
        else if (r < 45)
            mode = MODE_WR_DST;
        else if (r < 63)
            mode = MODE_RD_DST;
        else if (r < 81)
            mode = MODE_BLEND;
        else if (r < 97)
            mode = MODE_COPY;
        else
            mode = 3'($urandom_range(5, 7));
        if (mode == MODE_BLEND || mode == MODE_COPY)
            put_item(mode, pick_coord(cur_dw) - ($urandom_range(3) == 0 ? 4 : 0),
                     pick_coord(cur_dh) - ($urandom_range(3) == 0 ? 4 : 0),
                     pick_extent(cur_dw), pick_extent(cur_dh),
                     ($urandom_range(7) == 0) ? $urandom : $urandom_range(400) - 200,
                     ($urandom_range(7) == 0) ? $urandom : $urandom_range(400) - 200, tex);
        else
            put_item(mode, pick_coord(cur_dw), pick_coord(cur_dh), $urandom, $urandom,
                     pick_coord(cur_sw), pick_coord(cur_sh), tex);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats at the reset sizes.
        tx_idle = 8;
        rx_idle = 78;
        put_item(MODE_WR_SRC, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, 63, 63, 32'h80_40_20_10);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, 1, 0, 32'h00_C0_80_FF);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, -1, 0, 32'h1234_5678);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, 64, 5, 32'h1234_5678);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, 0, 32767, 32'h1234_5678);
        put_item(MODE_WR_SRC, 0, 0, 0, 0, -32768, -32768, 32'h1234_5678);
        put_item(MODE_WR_DST, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        put_item(MODE_WR_DST, 63, 63, 0, 0, 0, 0, 32'h8040_2010);
        put_item(MODE_WR_DST, 64, 0, 0, 0, 0, 0, 32'hDEAD_BEEF);
        put_item(MODE_RD_DST, 0, 0, 0, 0, 0, 0, '0);
        put_item(MODE_RD_DST, 63, 63, 0, 0, 0, 0, '0);
        put_item(MODE_RD_DST, -1, 0, 0, 0, 0, 0, '0);
        put_item(MODE_RD_DST, 0, 32767, 0, 0, 0, 0, '0);
        put_item(MODE_BLEND, -5, -7, 32767, 32767, -32768, 32767, '0);
        put_item(MODE_COPY, 2, 3, 4, 2, 62, 63, '0);
        put_item(MODE_COPY, 0, 0, 0, 5, 0, 0, '0);
        put_item(MODE_BLEND, 0, 0, 5, -32768, 0, 0, '0);
        put_item(MODE_COPY, 100, 0, 4, 4, 0, 0, '0);
        put_item(MODE_BLEND, -32768, -32768, 32767, 32767, 0, 0, '0);
        put_item(3'd5, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF);
        put_item(3'd6, 0, 0, 0, 0, 0, 0, '0);
        put_item(3'd7, -1, -1, -1, -1, -1, -1, 32'hFFFF_FFFF);
        put_item(MODE_RD_DST, 4, 3, 0, 0, 0, 0, '0);
        drain();

        // Register extremes, then random phases with changing sizes and idling.
        set_dims(0, 127, 1, 127);
        for (int k = 0; k < 8; k++)
            random_item();
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 8 : ((ph == 1) ? 78 : 0);
            rx_idle = (ph == 0) ? 78 : ((ph == 1) ? 8 : 0);
            for (int cs = 0; cs < 2; cs++) begin
                set_dims($urandom_range(1, 16), $urandom_range(1, 16),
                         ($urandom_range(4) == 0) ? 64 : $urandom_range(1, 16),
                         ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 16));
                for (int k = 0; k < 18; k++)
                    random_item();
                drain();
            end
        end
        set_dims(64, 64, 64, 64);
        put_item(MODE_COPY, 0, 0, 64, 64, 7, 9, '0);
        put_item(MODE_RD_DST, 63, 0, 0, 0, 0, 0, '0);
        drain();
        repeat (50) @(posedge aclk);

        $display("Run covered %0d beats, %0d blits drawing %0d texels in total.",
                 beats_in, blits_run, texels_drawn);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
